// File: rtl/tbeq_pkg.sv
package tbeq_pkg;

  localparam int DATA_W     = 32;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_SHIFT = 1;
  // product scaling: keep the upper word, then shift left by FRAC_SHIFT+1
  localparam int SCALE_SH   = FRAC_SHIFT + 1;
  localparam int SCALED_W   = DATA_W + SCALE_SH;
  localparam logic [DATA_W-1:0] UNITY   = 32'h4000_0000;
  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_COEF   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_COEF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_CENTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_COEF    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAIN    = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_WB
  } state_t;

  // one entry per product of the sample schedule
  typedef enum logic [3:0] {
    S_HI_N,
    S_HI_AP,
    S_HI_Y,
    S_PK_K,
    S_PK_A,
    S_PK_B,
    S_PK_AP,
    S_PK_Y,
    S_LO_N,
    S_LO_AP,
    S_LO_Y
  } step_t;

  typedef struct packed {
    logic  load;   // capture new input sample
    logic  mul;    // issue product for step
    logic  wb;     // retire product for step
    step_t step;
  } cmd_t;

  // floor(p / 2^32) scaled by 2^(FRAC_SHIFT+1), saturated to 32 bits
  function automatic logic [DATA_W-1:0] fmul_scale(input logic [PROD_W-1:0] p);
    logic [DATA_W-1:0]   q;
    logic [SCALED_W-1:0] r;
    logic [SCALE_SH:0]   top;
    q   = p[PROD_W-1:DATA_W];
    r   = {{SCALE_SH{q[DATA_W-1]}}, q} << SCALE_SH;
    top = r[SCALED_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return r[DATA_W-1:0];
    end else if (r[SCALED_W-1]) begin
      return SAT_MIN;
    end else begin
      return SAT_MAX;
    end
  endfunction

  // arithmetic shift right by one
  function automatic logic [DATA_W-1:0] half(input logic [DATA_W-1:0] v);
    return {v[DATA_W-1], v[DATA_W-1:1]};
  endfunction

endpackage

// File: rtl/tbeq_ctrl.sv
module tbeq_ctrl
  import tbeq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= S_HI_N;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.step      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready = rst_n;
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          step_nxt  = S_HI_N;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        if (step_r == S_LO_Y) begin
          // last product: wait until the output register is free
          if (!(out_valid_r && !out_ready)) begin
            cmd.wb        = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.wb    = 1'b1;
          step_nxt  = step_t'(step_r + 4'd1);
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/tbeq_dp.sv
module tbeq_dp
  import tbeq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [DATA_W-1:0]    in_sample,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output logic [DATA_W-1:0]    out_sample
);

  // configuration
  logic [DATA_W-1:0] high_coef_r, high_gain_r, peak_coef_r, peak_center_r;
  logic [DATA_W-1:0] peak_gain_r, low_coef_r, low_gain_r;
  // filter state
  logic [DATA_W-1:0] high_delay_r, peak_new_r, peak_old_r, low_delay_r;
  // working registers
  logic [DATA_W-1:0] x_r, n_r, d_r, e_r, k_r, out_r;
  logic [PROD_W-1:0] p_r;

  logic [DATA_W-1:0] op_a, op_b, m;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_coef_r   <= '0;
      high_gain_r   <= '0;
      peak_coef_r   <= '0;
      peak_center_r <= '0;
      peak_gain_r   <= '0;
      low_coef_r    <= '0;
      low_gain_r    <= '0;
    end else if (cfg_we) begin
      priority case (cfg_idx)
        CFG_HIGH_COEF:   high_coef_r   <= cfg_wdata;
        CFG_HIGH_GAIN:   high_gain_r   <= cfg_wdata;
        CFG_PEAK_COEF:   peak_coef_r   <= cfg_wdata;
        CFG_PEAK_CENTER: peak_center_r <= cfg_wdata;
        CFG_PEAK_GAIN:   peak_gain_r   <= cfg_wdata;
        CFG_LOW_COEF:    low_coef_r    <= cfg_wdata;
        CFG_LOW_GAIN:    low_gain_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    op_a = high_coef_r;
    op_b = high_delay_r;
    unique case (cmd.step)
      S_HI_N:  begin op_a = high_coef_r;   op_b = high_delay_r; end
      S_HI_AP: begin op_a = high_coef_r;   op_b = n_r;          end
      S_HI_Y:  begin op_a = high_gain_r;   op_b = d_r;          end
      S_PK_K:  begin op_a = peak_center_r; op_b = d_r;          end
      S_PK_A:  begin op_a = k_r;           op_b = peak_new_r;   end
      S_PK_B:  begin op_a = peak_coef_r;   op_b = peak_old_r;   end
      S_PK_AP: begin op_a = peak_coef_r;   op_b = d_r;          end
      S_PK_Y:  begin op_a = peak_gain_r;   op_b = d_r;          end
      S_LO_N:  begin op_a = low_coef_r;    op_b = low_delay_r;  end
      S_LO_AP: begin op_a = low_coef_r;    op_b = n_r;          end
      S_LO_Y:  begin op_a = low_gain_r;    op_b = d_r;          end
      default: begin op_a = high_coef_r;   op_b = high_delay_r; end
    endcase
  end

  assign m = fmul_scale(p_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_r <= PROD_W'($signed(op_a) * $signed(op_b));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_delay_r <= '0;
      peak_new_r   <= '0;
      peak_old_r   <= '0;
      low_delay_r  <= '0;
    end else if (cmd.wb) begin
      unique case (cmd.step)
        S_HI_AP: high_delay_r <= n_r;
        S_PK_AP: begin
          peak_old_r <= peak_new_r;
          peak_new_r <= n_r;
        end
        S_LO_AP: low_delay_r <= n_r;
        default: ;
      endcase
    end
  end

  // x - ap (or x + ap) is built ahead in e_r so each retire is a single add
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_sample;
    end else if (cmd.wb) begin
      unique case (cmd.step)
        S_HI_N: begin
          n_r <= x_r - m;
          e_r <= x_r - high_delay_r;
        end
        S_HI_AP: d_r <= e_r - m;
        S_HI_Y: begin
          x_r <= x_r + half(m);
          d_r <= UNITY - peak_coef_r;
        end
        S_PK_K: k_r <= m;
        S_PK_A: begin
          n_r <= x_r - m;
          e_r <= m - x_r;
        end
        S_PK_B: begin
          n_r <= n_r + m;
          d_r <= e_r - m;
          e_r <= n_r - peak_old_r;
        end
        S_PK_AP: d_r <= e_r - m;
        S_PK_Y:  x_r <= x_r + half(m);
        S_LO_N: begin
          n_r <= x_r - m;
          e_r <= x_r + low_delay_r;
        end
        S_LO_AP: d_r <= e_r + m;
        S_LO_Y:  out_r <= x_r + half(m);
        default: ;
      endcase
    end
  end

  assign out_sample = out_r;

endmodule

// File: rtl/three_band_allpass_equalizer.sv
// Three-band allpass equalizer: each sample transaction passes through a
// first-order allpass high shelf, a second-order allpass peak filter and a
// first-order allpass low shelf, and yields one output sample transaction.
// Every product runs on one shared 32x32 multiplier: eleven products per
// sample, each with an issue state (ST_MUL) and a retire state (ST_WB).
// out_valid rises with the final retire's write to the output register,
// and a new sample is taken only once the sequencer is back in ST_IDLE. The
// output register lets the next sample start while the previous result
// still waits to be taken; the final retire of that next sample holds until
// the register is free, which stretches the sample period by the receiver's stall.
// Coefficient and gain registers are written through the cfg port (ready
// whenever reset is released) and should only change while no sample is in
// flight. in_ready and cfg_ready are low while reset is held.
module three_band_allpass_equalizer
  import tbeq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input sample channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_sample_in,
  // output sample channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_sample_out,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  cmd_t cmd;

  // register writes never stall once out of reset
  assign cfg_ready = rst_n;

  // sequencer: walks the product schedule, owns the handshakes
  tbeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // datapath: config, filter state, shared multiplier, output register
  tbeq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_sample  (in_sample_in),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .out_sample (out_sample_out)
  );

  // an accepted sample always starts the schedule at the first product
  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.mul && cmd.step == S_HI_N)
    else $error("sample load not followed by first product");

  // a product issue is never directly followed by another issue
  a_mul_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> !cmd.mul)
    else $error("back-to-back multiplier issue");

  // the final retire never overwrites a result that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && cmd.step == S_LO_Y) |-> !(out_valid && !out_ready))
    else $error("output register overwritten while pending");

  // no new sample is taken in the cycle after one was accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while busy");

endmodule

// File: sim/three_band_allpass_equalizer_test.sv
module three_band_allpass_equalizer_test;
  import tbeq_pkg::*;

  // Cycles without any transaction on any channel before the run is called
  // hung. The longest wait with no transaction is the settle pause, or a 78%
  // receiver stall on top of the time a sample takes to process.
  localparam int WATCHDOG_LIMIT    = 2000;
  // Idle cycles before a register write. Every sample gives a result, so
  // this is only a margin past the block's latency.
  localparam int SETTLE_CYCLES     = 30;
  localparam int PHASES            = 8;
  localparam int SAMPLES_PER_PHASE = 50;
  // Index past the last register; the block ignores a write to it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_WRITE
  } row_kind_t;

  // One row of directed stimulus. A sample row with checked set carries the
  // result typed in by hand; otherwise the equalizer model decides.
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [DATA_W-1:0]     data;
    logic                  checked;
    logic [DATA_W-1:0]     golden;
  } stim_row_t;

  localparam int N_DIRECTED = 47;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // reset state: every gain is zero, so each sample passes unchanged
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff},
    '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, '0, 32'hffff_ffff, 1'b1, 32'hffff_ffff},
    '{ROW_SAMPLE, '0, 32'h0000_0001, 1'b1, 32'h0000_0001},
    '{ROW_SAMPLE, '0, 32'h5555_5555, 1'b1, 32'h5555_5555},
    '{ROW_SAMPLE, '0, 32'haaaa_aaaa, 1'b1, 32'haaaa_aaaa},
    // all registers at the positive limit: products saturate, sums wrap
    '{ROW_WRITE, CFG_HIGH_COEF,   32'h7fff_ffff, 1'b0, '0},
    '{ROW_WRITE, CFG_HIGH_GAIN,   32'h7fff_ffff, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_COEF,   32'h7fff_ffff, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_CENTER, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_GAIN,   32'h7fff_ffff, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_COEF,    32'h7fff_ffff, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_GAIN,    32'h7fff_ffff, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
    // all registers at the negative limit: min*min saturates once scaled
    '{ROW_WRITE, CFG_HIGH_COEF,   32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_HIGH_GAIN,   32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_COEF,   32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_CENTER, 32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_GAIN,   32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_COEF,    32'h8000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_GAIN,    32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7fff_ffff, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h1234_5678, 1'b0, '0},
    // write to an index with no register behind it must change nothing
    '{ROW_WRITE, CFG_UNUSED,      32'h7fff_ffff, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
    // plausible settings, then an impulse, silence and two more samples: the
    // ringing shows whether the older peak delay takes the previous newer word
    '{ROW_WRITE, CFG_HIGH_COEF,   32'h2000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_HIGH_GAIN,   32'h1000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_COEF,   32'h3000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_CENTER, 32'hc000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_GAIN,   32'h4000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_COEF,    32'he000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_GAIN,    32'hf000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h4000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'hc000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0100_0000, 1'b0, '0},
    // gains back to zero: output is the input whatever the delay state
    '{ROW_WRITE, CFG_HIGH_GAIN,   32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_PEAK_GAIN,   32'h0000_0000, 1'b0, '0},
    '{ROW_WRITE, CFG_LOW_GAIN,    32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h1357_2468, 1'b1, 32'h1357_2468}
  };

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [DATA_W-1:0]    in_sample_in   = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [DATA_W-1:0]    out_sample_out;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [DATA_W-1:0]    cfg_data       = '0;

  // pacing, in percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  int mismatches   = 0;
  int stall_cycles = 0;

  // output samples still owed by the block, oldest first
  logic [DATA_W-1:0] expected_q [$];
  logic [DATA_W-1:0] want_sample;

  // model copy of the coefficient registers
  logic [DATA_W-1:0] hs_coef = '0, hs_gain = '0;
  logic [DATA_W-1:0] pk_coef = '0, pk_cosine = '0, pk_gain = '0;
  logic [DATA_W-1:0] ls_coef = '0, ls_gain = '0;
  // model copy of the allpass delays; pk_z1 is the newer peak word
  logic [DATA_W-1:0] hs_z = '0, pk_z1 = '0, pk_z2 = '0, ls_z = '0;

  always #5 clk = ~clk;

  three_band_allpass_equalizer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Fractional product: exact 64-bit product, floor by 2^32, scale up by
  // 2^(FRAC_SHIFT+1), then clamp to the 32-bit range.
  function automatic logic [DATA_W-1:0] frac_mul(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic signed [63:0] sa, sb, prod, scaled;
    sa     = $signed(a);
    sb     = $signed(b);
    prod   = sa * sb;
    scaled = (prod >>> 32) <<< (FRAC_SHIFT + 1);
    if (scaled > 64'sd2147483647) begin
      return SAT_MAX;
    end else if (scaled < -64'sd2147483648) begin
      return SAT_MIN;
    end
    return scaled[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] shift_half(input logic [DATA_W-1:0] v);
    return $unsigned($signed(v) >>> 1);
  endfunction

  // Runs one sample through the three sections and advances the delays.
  function automatic logic [DATA_W-1:0] equalize_sample(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] y, n, ap, k;
    y = x;
    // high shelf: y + g*(y - ap)/2
    n    = y - frac_mul(hs_coef, hs_z);
    ap   = frac_mul(hs_coef, n) + hs_z;
    hs_z = n;
    y    = y + shift_half(frac_mul(hs_gain, y - ap));
    // peak: second-order allpass, older word takes the previous newer word
    k     = frac_mul(pk_cosine, UNITY - pk_coef);
    n     = y - frac_mul(k, pk_z1) + frac_mul(pk_coef, pk_z2);
    ap    = frac_mul(pk_coef, '0 - n) + frac_mul(k, pk_z1) + pk_z2;
    pk_z2 = pk_z1;
    pk_z1 = n;
    y     = y + shift_half(frac_mul(pk_gain, y - ap));
    // low shelf: y + g*(y + ap)/2
    n    = y - frac_mul(ls_coef, ls_z);
    ap   = frac_mul(ls_coef, n) + ls_z;
    ls_z = n;
    y    = y + shift_half(frac_mul(ls_gain, y + ap));
    return y;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] val);
    case (idx)
      CFG_HIGH_COEF:   hs_coef   = val;
      CFG_HIGH_GAIN:   hs_gain   = val;
      CFG_PEAK_COEF:   pk_coef   = val;
      CFG_PEAK_CENTER: pk_cosine = val;
      CFG_PEAK_GAIN:   pk_gain   = val;
      CFG_LOW_COEF:    ls_coef   = val;
      CFG_LOW_GAIN:    ls_gain   = val;
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2:       return '0;
      default: return UNITY;
    endcase
  endfunction

  // Register value: mostly within +/-UNITY, sometimes limits or anything.
  function automatic logic [DATA_W-1:0] coef_value();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return pick_extreme();
      default: return $urandom_range(32'h8000_0000) - UNITY;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_sample();
    case ($urandom_range(7))
      0:       return pick_extreme();
      1:       return $urandom_range(511) - 256;
      default: return $urandom;
    endcase
  endfunction

  // Offers one sample, keeping valid up across back-to-back transactions,
  // and books the predicted output once the block takes it.
  task automatic send_sample(input logic [DATA_W-1:0] v, input logic use_golden,
                             input logic [DATA_W-1:0] golden);
    logic [DATA_W-1:0] predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= v;
    do @(posedge clk); while (!in_ready);
    predicted = equalize_sample(v);
    expected_q.push_back(use_golden ? golden : predicted);
  endtask

  // Caller lowers cfg_valid after the last write of a batch.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, val);
  endtask

  // Registers change only with no sample in flight.
  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver side: ready drawn fresh every cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker: every output transaction against the oldest booking.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("sample_out unexpected: actual %h", out_sample_out);
        mismatches++;
      end else begin
        want_sample = expected_q.pop_front();
        if (out_sample_out !== want_sample) begin
          $error("sample_out mismatch: expected %h, actual %h",
                 want_sample, out_sample_out);
          mismatches++;
        end
      end
    end
  end

  // Hang detection: cycles since the last transaction on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk); while (stall_cycles < WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    stim_row_t row;
    bit        writing;
    writing = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling. A run of write rows is one batch, issued
    // once the block has drained.
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        if (!writing) begin
          in_valid <= 1'b0;
          wait_idle();
          writing = 1'b1;
        end
        write_reg(row.index, row.data);
      end else begin
        if (writing) begin
          cfg_valid <= 1'b0;
          writing = 1'b0;
        end
        send_sample(row.data, row.checked, row.golden);
      end
    end

    // Random phases: fresh settings each time, pacing rotating through
    // none, slow sender, slow receiver and light idling on both sides.
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_idle();
      write_reg(CFG_HIGH_COEF,   coef_value());
      write_reg(CFG_HIGH_GAIN,   coef_value());
      write_reg(CFG_PEAK_COEF,   coef_value());
      write_reg(CFG_PEAK_CENTER, coef_value());
      write_reg(CFG_PEAK_GAIN,   coef_value());
      write_reg(CFG_LOW_COEF,    coef_value());
      write_reg(CFG_LOW_GAIN,    coef_value());
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_UNUSED, $urandom);
      end
      cfg_valid <= 1'b0;
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int s = 0; s < SAMPLES_PER_PHASE; s++) begin
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
